>>> rtl/rpu_pkg.sv
// ----------------------------------------------------------------------------
// rpu_pkg
// shared types, register indexes and helpers of the pixel replication upscaler
// ----------------------------------------------------------------------------
package rpu_pkg;

	localparam int unsigned PIX_W     = 24;
	localparam int unsigned SCALE_W   = 5;
	localparam int unsigned WIDTH_W   = 13;
	localparam int unsigned MAX_SCALE = 16;
	localparam int unsigned CFG_IDX_W = 1;

	// item kinds
	localparam logic OP_PIXEL = 1'b0;
	localparam logic OP_PULL  = 1'b1;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SCALE     = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_ROW_WIDTH = 1'b1;

	typedef struct packed {
		logic       op;
		logic [7:0] red_in;
		logic [7:0] green_in;
		logic [7:0] blue_in;
	} rpu_in_t;

	typedef struct packed {
		logic [7:0] red_out;
		logic [7:0] green_out;
		logic [7:0] blue_out;
		logic [1:0] pad_after;
		logic       last;
	} rpu_out_t;

	// one replication job handed from control to the expander
	typedef struct packed {
		logic               from_store;
		logic [PIX_W-1:0]   pixel;
		logic               row_end;
		logic [1:0]         pad;
		logic [SCALE_W-1:0] copies_m1;
	} rpu_job_t;

	// zero bytes that bring 3*w*s bytes up to a multiple of four
	function automatic logic [1:0] pad_bytes(input logic [1:0] w2, input logic [1:0] s2);
		logic [3:0] prod;
		logic [1:0] rem;
		prod = 4'(w2) * 4'(s2);
		rem  = 2'(prod[1:0] * 2'd3);
		return 2'd0 - rem;
	endfunction

endpackage

>>> rtl/rpu_stream_if.sv
// ----------------------------------------------------------------------------
// rpu_stream_if
// valid/ready channel carrying one word of type T
// ----------------------------------------------------------------------------
interface rpu_stream_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/pixel_replication_upscaler.sv
// ----------------------------------------------------------------------------
// pixel_replication_upscaler
// integer nearest-neighbour upscaler for 24-bit rgb pixels
// ----------------------------------------------------------------------------
// Each accepted word gives scale output words, one per cycle while upscaled
// is ready; the replication counter in the expander counts the copies, and
// the next word may wait in the job register meanwhile. While loading,
// each pixel word is written to the line store and copied out at once. After
// a full input row of row_width pixels (and with scale above one) the block
// drains: each pull word reads the next stored pixel and copies it out, for
// scale-1 repeat rows. Words of the wrong kind for the phase are dropped with
// no output. The last copy of every output row carries the row's zero pad
// byte count in pad_after; last marks the final copy of each input word. The
// user writes scale and row_width only while idle; the block does not enforce
// it; a write restarts loading. The line store needs no clearing after reset.
// ----------------------------------------------------------------------------
module pixel_replication_upscaler #(
	parameter int unsigned MAX_WIDTH = 4096
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wr_en,
	input  logic [rpu_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rpu_pkg::WIDTH_W-1:0]   cfg_data,
	rpu_stream_if.sink                   pixels,
	rpu_stream_if.source                 upscaled
);
	import rpu_pkg::*;

	// column counter and line store address width
	localparam int unsigned CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

	logic             mem_wr_en;
	logic             mem_rd_en;
	logic [CW-1:0]    mem_addr;
	logic [PIX_W-1:0] mem_wr_data;
	logic [PIX_W-1:0] mem_rd_data;
	logic             job_valid;
	rpu_job_t         job;
	logic             job_take;

	// phase tracking, at most one line store access per accepted word
	rpu_ctrl #(
		.MAX_WIDTH (MAX_WIDTH),
		.CW        (CW)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.pixels      (pixels),
		.mem_wr_en   (mem_wr_en),
		.mem_rd_en   (mem_rd_en),
		.mem_addr    (mem_addr),
		.mem_wr_data (mem_wr_data),
		.job_valid   (job_valid),
		.job         (job),
		.job_take    (job_take)
	);

	// one row of input pixels; read data lands with the job register
	rpu_line_store #(
		.DEPTH (MAX_WIDTH),
		.AW    (CW)
	) u_line_store (
		.clk     (clk),
		.wr_en   (mem_wr_en),
		.wr_addr (mem_addr),
		.wr_data (mem_wr_data),
		.rd_en   (mem_rd_en),
		.rd_addr (mem_addr),
		.rd_data (mem_rd_data)
	);

	// replication onto the output channel, output word registered
	rpu_expand u_expand (
		.clk        (clk),
		.arst_n     (arst_n),
		.job_valid  (job_valid),
		.job        (job),
		.store_data (mem_rd_data),
		.job_take   (job_take),
		.upscaled   (upscaled)
	);

endmodule

>>> rtl/rpu_line_store.sv
// ----------------------------------------------------------------------------
// rpu_line_store
// single-port-write, single-port-read line memory, registered read data
// ----------------------------------------------------------------------------
module rpu_line_store #(
	parameter int unsigned DEPTH = 4096,
	parameter int unsigned AW    = 12
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [AW-1:0]            wr_addr,
	input  logic [rpu_pkg::PIX_W-1:0] wr_data,
	input  logic                     rd_en,
	input  logic [AW-1:0]            rd_addr,
	output logic [rpu_pkg::PIX_W-1:0] rd_data
);
	import rpu_pkg::*;

	logic [PIX_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

>>> rtl/rpu_ctrl.sv
// ----------------------------------------------------------------------------
// rpu_ctrl
// configuration, row phase tracking, line store access and job register
// ----------------------------------------------------------------------------
module rpu_ctrl #(
	parameter int unsigned MAX_WIDTH = 4096,
	parameter int unsigned CW        = 12
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wr_en,
	input  logic [rpu_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rpu_pkg::WIDTH_W-1:0]   cfg_data,
	rpu_stream_if.sink                   pixels,
	output logic                         mem_wr_en,
	output logic                         mem_rd_en,
	output logic [CW-1:0]                mem_addr,
	output logic [rpu_pkg::PIX_W-1:0]     mem_wr_data,
	output logic                         job_valid,
	output rpu_pkg::rpu_job_t            job,
	input  logic                         job_take
);
	import rpu_pkg::*;

	localparam int unsigned WLIM = (MAX_WIDTH < 8191) ? MAX_WIDTH : 8191;
	localparam int unsigned SLIM = (MAX_SCALE < 31) ? MAX_SCALE : 31;

	logic [SCALE_W-1:0] scale_q;
	logic [WIDTH_W-1:0] row_width_q;
	logic [CW-1:0]      column_q;
	logic [SCALE_W-1:0] rep_done_q;
	logic               draining_q;
	logic               valid_s1;
	rpu_job_t           job_s1;

	logic [SCALE_W-1:0] s_nz, s_eff;
	logic [WIDTH_W-1:0] w_nz, w_eff;
	logic [CW-1:0]      col_last;
	logic [1:0]         pad;
	logic               accept, is_load, is_pull, take, row_end;
	logic [PIX_W-1:0]   pix;

	// effective scale and width after clamping
	always_comb begin
		s_nz     = (scale_q == '0) ? SCALE_W'(1) : scale_q;
		s_eff    = (s_nz > SCALE_W'(SLIM)) ? SCALE_W'(SLIM) : s_nz;
		w_nz     = (row_width_q == '0) ? WIDTH_W'(1) : row_width_q;
		w_eff    = (w_nz > WIDTH_W'(WLIM)) ? WIDTH_W'(WLIM) : w_nz;
		col_last = CW'(w_eff - WIDTH_W'(1));
		pad      = pad_bytes(w_eff[1:0], s_eff[1:0]);
	end

	assign pixels.ready = !valid_s1 || job_take;
	assign accept       = pixels.valid && pixels.ready;
	assign is_load      = !draining_q && (pixels.data.op == OP_PIXEL);
	assign is_pull      = draining_q && (pixels.data.op == OP_PULL);
	assign take         = accept && (is_load || is_pull);
	assign row_end      = (column_q == col_last);
	assign pix          = {pixels.data.red_in, pixels.data.green_in, pixels.data.blue_in};

	assign mem_wr_en   = accept && is_load;
	assign mem_rd_en   = accept && is_pull;
	assign mem_addr    = column_q;
	assign mem_wr_data = pix;

	assign job_valid = valid_s1;
	assign job       = job_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q     <= SCALE_W'(1);
			row_width_q <= WIDTH_W'(1);
			column_q    <= '0;
			rep_done_q  <= '0;
			draining_q  <= 1'b0;
			valid_s1    <= 1'b0;
		end else begin
			if (take) begin
				valid_s1 <= 1'b1;
			end else if (job_take) begin
				valid_s1 <= 1'b0;
			end
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_SCALE:     scale_q     <= cfg_data[SCALE_W-1:0];
					REG_ROW_WIDTH: row_width_q <= cfg_data;
					default:       ;
				endcase
				column_q   <= '0;
				rep_done_q <= '0;
				draining_q <= 1'b0;
			end else if (take) begin
				if (!row_end) begin
					column_q <= column_q + CW'(1);
				end else begin
					column_q <= '0;
					if (is_load) begin
						rep_done_q <= '0;
						draining_q <= (s_eff > SCALE_W'(1));
					end else if (rep_done_q + SCALE_W'(1) >= s_eff - SCALE_W'(1)) begin
						rep_done_q <= '0;
						draining_q <= 1'b0;
					end else begin
						rep_done_q <= rep_done_q + SCALE_W'(1);
					end
				end
			end
		end
	end

	// job payload, no reset needed
	always_ff @(posedge clk) begin
		if (take) begin
			job_s1.from_store <= is_pull;
			job_s1.pixel      <= pix;
			job_s1.row_end    <= row_end;
			job_s1.pad        <= pad;
			job_s1.copies_m1  <= s_eff - SCALE_W'(1);
		end
	end

endmodule

>>> rtl/rpu_expand.sv
// ----------------------------------------------------------------------------
// rpu_expand
// repeats one pixel scale times onto the output channel
// ----------------------------------------------------------------------------
module rpu_expand (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     job_valid,
	input  rpu_pkg::rpu_job_t        job,
	input  logic [rpu_pkg::PIX_W-1:0] store_data,
	output logic                     job_take,
	rpu_stream_if.source             upscaled
);
	import rpu_pkg::*;

	logic               out_valid_q;
	logic [PIX_W-1:0]   pixel_q;
	logic [SCALE_W-1:0] left_q;
	logic               row_end_q;
	logic [1:0]         pad_q;
	logic               final_copy;

	assign final_copy = (left_q == '0);
	assign job_take   = job_valid && (!out_valid_q || (upscaled.ready && final_copy));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (job_take) begin
			out_valid_q <= 1'b1;
		end else if (upscaled.ready && final_copy) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (job_take) begin
			pixel_q   <= job.from_store ? store_data : job.pixel;
			left_q    <= job.copies_m1;
			row_end_q <= job.row_end;
			pad_q     <= job.pad;
		end else if (out_valid_q && upscaled.ready && !final_copy) begin
			left_q <= left_q - SCALE_W'(1);
		end
	end

	assign upscaled.valid          = out_valid_q;
	assign upscaled.data.red_out   = pixel_q[23:16];
	assign upscaled.data.green_out = pixel_q[15:8];
	assign upscaled.data.blue_out  = pixel_q[7:0];
	assign upscaled.data.pad_after = (final_copy && row_end_q) ? pad_q : 2'd0;
	assign upscaled.data.last      = final_copy;

endmodule
